// ----- rtl/core/klpi_pkg.sv -----
// shared types, codes and key/hash helpers for the keyed linear probe index
package klpi_pkg;

  // request codes carried in the low bits of in_tuser
  typedef enum logic [1:0] {
    CMD_LOOKUP_NAME = 2'd0,
    CMD_LOOKUP_ID   = 2'd1,
    CMD_INSERT      = 2'd2
  } cmd_t;

  // result codes carried in out_tuser
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // one stored entry record
  typedef struct packed {
    logic [31:0] key_id;
    logic [63:0] key_name;
    logic [23:0] key_type;
  } record_t;

  // hash unit results toward the controller
  typedef struct packed {
    logic        done;
    logic [31:0] name_crc;
    logic [31:0] id_crc;
  } hash_stat_t;

  localparam int unsigned KEY_BYTES = 11;  // type then name
  localparam int unsigned ID_BYTES  = 7;   // type then id, low byte first
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  // zero every byte after the first zero byte and upper-case a..z
  function automatic logic [63:0] norm_key(input logic [63:0] v);
    logic [63:0] r;
    logic        ended;
    logic [7:0]  b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = v[i*8 +: 8];
      if (b == 8'h00) ended = 1'b1;
      if (ended) b = 8'h00;
      if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
      r[i*8 +: 8] = b;
    end
    return r;
  endfunction

  // reflected crc-32 update by one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ----- rtl/core/klpi_hash.sv -----
// byte-serial crc-32 unit computing the name key and id key hashes together
module klpi_hash (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [23:0]           key_type,
  input  logic [63:0]           key_name,
  input  logic [31:0]           key_id,
  output klpi_pkg::hash_stat_t  stat
);

  localparam logic [3:0] LAST_BYTE = 4'(klpi_pkg::KEY_BYTES - 1);
  localparam logic [3:0] ID_END    = 4'(klpi_pkg::ID_BYTES);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  byte_idx_r;
  logic [31:0] crc_n_r;
  logic [31:0] crc_i_r;

  logic [87:0] key_n;
  logic [55:0] key_i;
  logic [7:0]  byte_n;
  logic [7:0]  byte_i;

  // key byte streams, first byte lowest
  assign key_n  = {key_name, key_type};
  assign key_i  = {key_id, key_type};
  assign byte_n = key_n[{byte_idx_r, 3'b000} +: 8];
  assign byte_i = key_i[{byte_idx_r[2:0], 3'b000} +: 8];

  // control: one byte per cycle, done pulses after the last name byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      byte_idx_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r     <= 1'b1;
        byte_idx_r <= '0;
      end else if (busy_r) begin
        byte_idx_r <= byte_idx_r + 4'd1;
        if (byte_idx_r == LAST_BYTE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // crc datapath, the id crc stops after its shorter key
  always_ff @(posedge clk) begin
    if (start) begin
      crc_n_r <= klpi_pkg::CRC_INIT;
      crc_i_r <= klpi_pkg::CRC_INIT;
    end else if (busy_r) begin
      crc_n_r <= klpi_pkg::crc32_byte(crc_n_r, byte_n);
      if (byte_idx_r < ID_END) begin
        crc_i_r <= klpi_pkg::crc32_byte(crc_i_r, byte_i);
      end
    end
  end

  assign stat.done     = done_r;
  assign stat.name_crc = ~crc_n_r;
  assign stat.id_crc   = ~crc_i_r;

endmodule

// ----- rtl/core/keyed_linear_probe_index_core.sv -----
// keyed linear probe index: crc-32 hashed open addressing over slot and record memories
// flow: the byte-serial hash runs first, then each probe reads a slot and, when it is occupied,
//   its record; an insert with an id then walks the id table from the id hash likewise
// throughput: one item at a time, the next accepted the cycle after the result moves to
//   the output register, which waits while the previous result is unaccepted
// reset: a clearing pass empties both slot tables, input held off
module keyed_linear_probe_index_core #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // key_type[23:0], key_name[87:24], key_id[119:88]
  input  logic [2:0]   in_tuser,   // command[1:0], has_id[2]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // entry_number[7:0], slot_number[15:8], entries_used[23:16]
  output logic [2:0]   out_tuser   // status[2:0]
);

  localparam int unsigned AW  = $clog2(TABLE_SIZE);
  localparam int unsigned RAW = AW - 1;
  localparam logic [AW-1:0] CAPACITY   = AW'(TABLE_SIZE / 2);
  localparam logic [AW-1:0] LAST_PROBE = AW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_SLOT,
    S_REC,
    S_DONE
  } state_t;

  // memories: slot tables (name half, id half) and entry records
  logic [AW-1:0]      slot_mem [2*TABLE_SIZE];
  klpi_pkg::record_t  rec_mem  [TABLE_SIZE/2];

  logic [AW-1:0]      slot_q_r;
  klpi_pkg::record_t  rec_q_r;

  logic               slot_we, slot_re, rec_we, rec_re;
  logic [AW:0]        slot_wa, slot_ra;
  logic [AW-1:0]      slot_wd;
  logic [RAW-1:0]     rec_wa, rec_ra;
  klpi_pkg::record_t  rec_wd;

  // control and request registers
  state_t             state_r, state_nxt;
  logic [AW:0]        clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]      count_r, count_nxt;
  klpi_pkg::cmd_t     cmd_r, cmd_nxt;
  logic               has_id_r, has_id_nxt;
  logic [23:0]        type_r, type_nxt;
  logic [63:0]        name_r, name_nxt;
  logic [31:0]        id_r, id_nxt;
  logic               sel_r, sel_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [AW-1:0]      start_slot_r, start_slot_nxt;
  logic [AW-1:0]      probe_cnt_r, probe_cnt_nxt;
  logic [AW-1:0]      sval_r, sval_nxt;
  klpi_pkg::status_t  res_status_r, res_status_nxt;
  logic [RAW-1:0]     res_entry_r, res_entry_nxt;
  logic [AW-1:0]      res_slot_r, res_slot_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  klpi_pkg::status_t  out_status_r, out_status_nxt;
  logic [7:0]         out_entry_r, out_entry_nxt;
  logic [7:0]         out_slot_r, out_slot_nxt;
  logic [7:0]         out_used_r, out_used_nxt;

  logic               hash_start;
  klpi_pkg::hash_stat_t hash_stat;
  logic [63:0]        norm_type;
  logic               rec_hit, id_phase;
  logic               stop_empty, stop_hit, stop_fail;

  klpi_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_start),
    .key_type (type_r),
    .key_name (name_r),
    .key_id   (id_r),
    .stat     (hash_stat)
  );

  assign norm_type = klpi_pkg::norm_key({40'h00_0000_0000, in_tdata[23:0]});
  assign id_phase  = sel_r && (cmd_r == klpi_pkg::CMD_INSERT);
  assign rec_hit   = (rec_q_r.key_type == type_r) &&
                     (sel_r ? (rec_q_r.key_id == id_r) : (rec_q_r.key_name == name_r));

  // next-state and memory control
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    has_id_nxt     = has_id_r;
    type_nxt       = type_r;
    name_nxt       = name_r;
    id_nxt         = id_r;
    sel_nxt        = sel_r;
    slot_nxt       = slot_r;
    start_slot_nxt = start_slot_r;
    probe_cnt_nxt  = probe_cnt_r;
    sval_nxt       = sval_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    res_slot_nxt   = res_slot_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_slot_nxt   = out_slot_r;
    out_used_nxt   = out_used_r;
    hash_start     = 1'b0;
    slot_we        = 1'b0;
    slot_wa        = {1'b0, slot_r};
    slot_wd        = count_r;
    slot_re        = 1'b0;
    slot_ra        = {sel_r, slot_r};
    rec_we         = 1'b0;
    rec_wa         = count_r[RAW-1:0];
    rec_wd         = '{key_id: id_r, key_name: name_r, key_type: type_r};
    rec_re         = 1'b0;
    rec_ra         = RAW'(slot_q_r - 1'b1);
    stop_empty     = 1'b0;
    stop_hit       = 1'b0;
    stop_fail      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        slot_we     = 1'b1;
        slot_wa     = clr_idx_r;
        slot_wd     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = klpi_pkg::cmd_t'(in_tuser[1:0]);
          has_id_nxt = in_tuser[2];
          type_nxt   = norm_type[23:0];
          name_nxt   = klpi_pkg::norm_key(in_tdata[87:24]);
          id_nxt     = in_tdata[119:88];
          case (in_tuser[1:0]) inside
            klpi_pkg::CMD_LOOKUP_NAME, klpi_pkg::CMD_LOOKUP_ID, klpi_pkg::CMD_INSERT: begin
              hash_start = 1'b1;
              state_nxt  = S_HASH;
            end
            default: begin
              // unknown request: no change, not found
              res_status_nxt = klpi_pkg::ST_NOT_FOUND;
              res_entry_nxt  = '0;
              res_slot_nxt   = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hash_stat.done) begin
          sel_nxt        = (cmd_r == klpi_pkg::CMD_LOOKUP_ID);
          slot_nxt       = (cmd_r == klpi_pkg::CMD_LOOKUP_ID) ?
                           hash_stat.id_crc[AW-1:0] : hash_stat.name_crc[AW-1:0];
          start_slot_nxt = slot_nxt;
          probe_cnt_nxt  = '0;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        slot_re   = 1'b1;
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        if (slot_q_r == '0) begin
          stop_empty = 1'b1;
        end else begin
          sval_nxt  = slot_q_r;
          rec_re    = 1'b1;
          state_nxt = S_REC;
        end
      end
      S_REC: begin
        if (rec_hit) begin
          stop_hit = 1'b1;
        end else if (probe_cnt_r == LAST_PROBE) begin
          stop_fail = 1'b1;
        end else begin
          slot_nxt      = slot_r + 1'b1;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = 8'(res_entry_r);
          out_slot_nxt   = 8'(res_slot_r);
          out_used_nxt   = 8'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of a probe walk
    if (stop_empty || stop_hit || stop_fail) begin
      state_nxt = S_DONE;
      if (id_phase) begin
        // id slot of a new entry: point it at the entry unless the walk failed
        if (!stop_fail) begin
          slot_we = 1'b1;
          slot_wa = {1'b1, slot_r};
          slot_wd = count_r;
        end
      end else if (stop_fail) begin
        res_status_nxt = klpi_pkg::ST_FULL;
        res_entry_nxt  = '0;
        res_slot_nxt   = start_slot_r;
      end else if (stop_hit) begin
        res_status_nxt = (cmd_r == klpi_pkg::CMD_INSERT) ?
                         klpi_pkg::ST_PRESENT : klpi_pkg::ST_FOUND;
        res_entry_nxt  = RAW'(sval_r - 1'b1);
        res_slot_nxt   = slot_r;
      end else if (cmd_r != klpi_pkg::CMD_INSERT) begin
        res_status_nxt = klpi_pkg::ST_NOT_FOUND;
        res_entry_nxt  = '0;
        res_slot_nxt   = slot_r;
      end else if (count_r >= CAPACITY) begin
        res_status_nxt = klpi_pkg::ST_FULL;
        res_entry_nxt  = '0;
        res_slot_nxt   = slot_r;
      end else begin
        // append record, fill the name slot, then walk the id table if asked
        rec_we         = 1'b1;
        slot_we        = 1'b1;
        slot_wa        = {1'b0, slot_r};
        slot_wd        = count_r + 1'b1;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = klpi_pkg::ST_INSERTED;
        res_entry_nxt  = count_r[RAW-1:0];
        res_slot_nxt   = slot_r;
        if (has_id_r) begin
          sel_nxt        = 1'b1;
          slot_nxt       = hash_stat.id_crc[AW-1:0];
          start_slot_nxt = hash_stat.id_crc[AW-1:0];
          probe_cnt_nxt  = '0;
          state_nxt      = S_READ;
        end
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r        <= cmd_nxt;
    has_id_r     <= has_id_nxt;
    type_r       <= type_nxt;
    name_r       <= name_nxt;
    id_r         <= id_nxt;
    sel_r        <= sel_nxt;
    slot_r       <= slot_nxt;
    start_slot_r <= start_slot_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    sval_r       <= sval_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_slot_r   <= out_slot_nxt;
    out_used_r   <= out_used_nxt;
  end

  // slot table memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_q_r <= slot_mem[slot_ra];
  end

  // entry record memory
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_q_r <= rec_mem[rec_ra];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_used_r, out_slot_r, out_entry_r};

  // entry count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAPACITY)
    else $error("entry count above capacity");

  // a record is only appended below capacity
  a_rec_write: assert property (@(posedge clk) disable iff (!rst_n)
    rec_we |-> (count_r < CAPACITY))
    else $error("record append at capacity");

  // the entry count only ever steps up by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + 1'b1))
    else $error("entry count jumped");

  // hash results arrive only while the controller waits for them
  a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
    hash_stat.done |-> (state_r == S_HASH))
    else $error("hash done outside hash wait");

endmodule

// ----- dv/klpi_tb_pkg.sv -----
// request and result types and the scoreboard for the keyed linear probe index bench
`timescale 1ns / 100ps
package klpi_tb_pkg;

  localparam int unsigned TBL = 256;
  // command code that the block has to ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one request as driven on the input channel
  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] key_type;
    logic [63:0] key_name;
    logic [31:0] key_id;
    logic        has_id;
  } request_t;

  // one answer as seen on the result channel
  typedef struct packed {
    klpi_pkg::status_t status;
    logic [7:0]        entry_number;
    logic [7:0]        slot_number;
    logic [7:0]        entries_used;
  } answer_t;

  // zero the bytes after the first zero byte and fold a..z to upper case
  function automatic logic [63:0] fold_key(input logic [63:0] v, input int unsigned nb);
    logic [63:0] r;
    bit          ended;
    logic [7:0]  b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < nb; i++) begin
      b = v[i*8 +: 8];
      if (b == 8'h00) ended = 1'b1;
      if (ended) b = 8'h00;
      if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
      r[i*8 +: 8] = b;
    end
    return r;
  endfunction

  // reflected crc-32 over the low nb bytes, first byte in bits 7:0
  function automatic logic [31:0] key_crc(input logic [87:0] bytes, input int unsigned nb);
    logic [31:0] c;
    c = klpi_pkg::CRC_INIT;
    for (int i = 0; i < nb; i++) begin
      c = c ^ {24'h00_0000, bytes[i*8 +: 8]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ klpi_pkg::CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  class index_scoreboard;
    logic [23:0] rec_type [TBL];
    logic [63:0] rec_name [TBL];
    logic [31:0] rec_id   [TBL];
    logic [8:0]  name_slot[TBL];
    logic [8:0]  id_slot  [TBL];
    int unsigned stored;
    answer_t     pending_q[$];
    int unsigned fail_count;
    int unsigned accepted;
    int unsigned seen;
    int unsigned per_status[5];

    function new();
      for (int i = 0; i < TBL; i++) begin
        rec_type[i]  = '0;
        rec_name[i]  = '0;
        rec_id[i]    = '0;
        name_slot[i] = '0;
        id_slot[i]   = '0;
      end
      stored     = 0;
      fail_count = 0;
      accepted   = 0;
      seen       = 0;
      for (int i = 0; i < 5; i++) per_status[i] = 0;
    endfunction

    // linear probe from the hashed slot; stops at an empty or matching slot, fails after a full lap
    function bit walk(input bit by_id, input logic [23:0] t, input logic [63:0] nm,
                      input logic [31:0] id, output int unsigned slot);
      logic [87:0] k;
      int unsigned first;
      int unsigned s;
      int unsigned e;
      logic [8:0]  v;
      bit          hit;
      k     = by_id ? {32'h0, id, t} : {nm, t};
      first = key_crc(k, by_id ? 7 : 11) & (TBL - 1);
      s     = first;
      for (int i = 0; i < TBL; i++) begin
        v = by_id ? id_slot[s] : name_slot[s];
        if (v == 9'd0) begin
          slot = s;
          return 1'b1;
        end
        e   = (v - 1) & (TBL - 1);
        hit = (rec_type[e] == t) && (by_id ? rec_id[e] == id : rec_name[e] == nm);
        if (hit) begin
          slot = s;
          return 1'b1;
        end
        s = (s + 1) & (TBL - 1);
      end
      slot = first;
      return 1'b0;
    endfunction

    // work out the answer to an accepted request and update the index copy
    function void note_input(input request_t r);
      logic [23:0]       t;
      logic [63:0]       nm;
      int unsigned       s;
      int unsigned       s2;
      int unsigned       ent;
      bit                ok;
      klpi_pkg::status_t st;
      answer_t           a;
      t   = 24'(fold_key({40'h0, r.key_type}, 3));
      nm  = fold_key(r.key_name, 8);
      st  = klpi_pkg::ST_NOT_FOUND;
      ent = 0;
      s   = 0;
      case (r.cmd) inside
        klpi_pkg::CMD_LOOKUP_NAME, klpi_pkg::CMD_LOOKUP_ID: begin
          ok = walk(r.cmd == klpi_pkg::CMD_LOOKUP_ID, t, nm, r.key_id, s);
          if (!ok) begin
            st = klpi_pkg::ST_FULL;
          end else if ((r.cmd == klpi_pkg::CMD_LOOKUP_ID ? id_slot[s] : name_slot[s])
                       != 9'd0) begin
            st  = klpi_pkg::ST_FOUND;
            ent = (r.cmd == klpi_pkg::CMD_LOOKUP_ID ? id_slot[s] : name_slot[s]) - 1;
          end
        end
        klpi_pkg::CMD_INSERT: begin
          ok = walk(1'b0, t, nm, r.key_id, s);
          if (!ok) begin
            st = klpi_pkg::ST_FULL;
          end else if (name_slot[s] != 9'd0) begin
            st  = klpi_pkg::ST_PRESENT;
            ent = name_slot[s] - 1;
          end else if (2 * stored >= TBL) begin
            st = klpi_pkg::ST_FULL;
          end else begin
            ent           = stored;
            rec_type[ent] = t;
            rec_name[ent] = nm;
            rec_id[ent]   = r.key_id;
            name_slot[s]  = 9'(ent + 1);
            stored        = stored + 1;
            // the id index is repointed when the same type and id is already there
            if (r.has_id && walk(1'b1, t, nm, r.key_id, s2)) id_slot[s2] = 9'(ent + 1);
            st = klpi_pkg::ST_INSERTED;
          end
        end
        default: ;
      endcase
      a.status       = st;
      a.entry_number = 8'(ent);
      a.slot_number  = 8'(s);
      a.entries_used = 8'(stored);
      pending_q.push_back(a);
      accepted++;
      per_status[st]++;
    endfunction

    // compare one answer from the block with the oldest one waiting
    function void check_result(input answer_t got);
      answer_t want;
      seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d entry %0d slot %0d used %0d",
               got.status, got.entry_number, got.slot_number, got.entries_used);
        fail_count++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.entry_number != want.entry_number) begin
        $error("entry_number: expected %0d, actual %0d", want.entry_number, got.entry_number);
        fail_count++;
      end
      if (got.slot_number != want.slot_number) begin
        $error("slot_number: expected %0d, actual %0d", want.slot_number, got.slot_number);
        fail_count++;
      end
      if (got.entries_used != want.entries_used) begin
        $error("entries_used: expected %0d, actual %0d", want.entries_used, got.entries_used);
        fail_count++;
      end
    endfunction

    function int unsigned waiting();
      return pending_q.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// top-level bench for the keyed linear probe index core
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned MAX_GAP      = 8;
  localparam int unsigned RX_PERIOD    = 150;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TBL          = klpi_tb_pkg::TBL;
  // worst item: two full probe walks, a sender gap and a long receiver stall
  localparam int unsigned LIMIT =
    4 * (2 * TBL + (RANDOM_ITEMS + 32) * (18 + 6 * TBL + MAX_GAP + 64));

  // known type codes, first byte in bits 7:0
  localparam logic [23:0] TYPE_SET [0:6] = '{
    24'h534552, 24'h444E53, 24'h434950, 24'h544144,
    24'h50414D, 24'h514553, 24'h004653
  };

  typedef struct {
    logic [23:0] key_type;
    logic [63:0] key_name;
    logic [31:0] key_id;
  } pool_key_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic [2:0]   out_tuser;

  klpi_tb_pkg::index_scoreboard sb = new();
  pool_key_t       key_pool[$];
  int unsigned     cycles  = 0;
  int unsigned     rx_tick = 0;
  int unsigned     rx_mode = 0;

  keyed_linear_probe_index_core #(.TABLE_SIZE(TBL)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.waiting());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: check accepted items, then pick the next ready value
  always @(posedge clk) begin
    klpi_tb_pkg::answer_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status       = klpi_pkg::status_t'(out_tuser);
      got.entry_number = out_tdata[7:0];
      got.slot_number  = out_tdata[15:8];
      got.entries_used = out_tdata[23:16];
      sb.check_result(got);
    end
    rx_tick++;
    if (rx_tick == RX_PERIOD) begin
      rx_tick = 0;
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0, 1:    out_tready <= 1'b1;
      2:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // drive one request and hold it until the block takes it
  task automatic push_request(input klpi_tb_pkg::request_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {r.key_id, r.key_name, r.key_type};
    in_tuser  <= {r.has_id, r.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(r);
  endtask

  function automatic klpi_tb_pkg::request_t mk(input logic [1:0] cmd, input logic [23:0] t,
                                               input logic [63:0] nm, input logic [31:0] id,
                                               input logic hid);
    klpi_tb_pkg::request_t r;
    r.cmd      = cmd;
    r.key_type = t;
    r.key_name = nm;
    r.key_id   = id;
    r.has_id   = hid;
    return r;
  endfunction

  // same key after folding: random case and garbage after the terminator
  function automatic logic [63:0] disguise(input logic [63:0] v, input int unsigned nb);
    logic [63:0] r;
    logic [7:0]  b;
    bit          ended;
    r     = v;
    ended = 1'b0;
    for (int i = 0; i < nb; i++) begin
      b = v[i*8 +: 8];
      if (ended) begin
        if ($urandom_range(0, 1) == 1) b = 8'($urandom);
      end else if (b == 8'h00) begin
        ended = 1'b1;
      end else if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
        b = b ^ 8'h20;
      end
      r[i*8 +: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [23:0] fresh_type();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(disguise({40'h0, TYPE_SET[$urandom_range(0, 6)]}, 3));
  endfunction

  function automatic logic [63:0] fresh_name();
    logic [63:0]  r;
    int unsigned  len;
    int unsigned  c;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    r   = '0;
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      c = $urandom_range(0, 62);
      if (c < 26)      r[i*8 +: 8] = 8'(8'h41 + c);
      else if (c < 52) r[i*8 +: 8] = 8'(8'h61 + c - 26);
      else if (c < 62) r[i*8 +: 8] = 8'(8'h30 + c - 52);
      else             r[i*8 +: 8] = 8'h5F;
    end
    return disguise(r, 8);
  endfunction

  function automatic logic [31:0] fresh_id();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 999);
  endfunction

  // random request: mostly keys already known, some new ones and some noise
  function automatic klpi_tb_pkg::request_t make_req();
    klpi_tb_pkg::request_t r;
    pool_key_t   p;
    int unsigned pick;
    bit          known;
    pick  = $urandom_range(0, 99);
    known = (key_pool.size() != 0) && ($urandom_range(0, 4) != 0);
    if (key_pool.size() != 0) p = key_pool[$urandom_range(0, key_pool.size() - 1)];
    r = mk(klpi_tb_pkg::CMD_UNUSED, 24'($urandom), {$urandom, $urandom}, $urandom,
           1'($urandom_range(0, 1)));
    if (pick < 5) begin
      return r;
    end else if (pick < 35) begin
      r.cmd = klpi_pkg::CMD_LOOKUP_NAME;
      if (known) begin
        r.key_type = 24'(disguise({40'h0, p.key_type}, 3));
        r.key_name = disguise(p.key_name, 8);
      end else begin
        r.key_type = fresh_type();
        r.key_name = fresh_name();
      end
    end else if (pick < 60) begin
      r.cmd = klpi_pkg::CMD_LOOKUP_ID;
      if (known) begin
        r.key_type = 24'(disguise({40'h0, p.key_type}, 3));
        r.key_id   = p.key_id;
      end else begin
        r.key_type = fresh_type();
        r.key_id   = fresh_id();
      end
    end else begin
      r.cmd    = klpi_pkg::CMD_INSERT;
      r.has_id = ($urandom_range(0, 9) < 7);
      if (known && $urandom_range(0, 1) == 1) begin
        // key already present, possibly under a different spelling
        r.key_type = 24'(disguise({40'h0, p.key_type}, 3));
        r.key_name = disguise(p.key_name, 8);
        r.key_id   = fresh_id();
      end else begin
        r.key_name = fresh_name();
        if (known && $urandom_range(0, 2) == 0) begin
          // same type and id as a known entry: with has_id set, repoints the id slot
          r.key_type = 24'(disguise({40'h0, p.key_type}, 3));
          r.key_id   = p.key_id;
        end else begin
          r.key_type = fresh_type();
          r.key_id   = fresh_id();
        end
        p.key_type = r.key_type;
        p.key_name = r.key_name;
        p.key_id   = r.key_id;
        key_pool.push_back(p);
      end
    end
    return r;
  endfunction

  // stimulus
  initial begin
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty index, unknown command, case folding, extremes, id repoint
    push_request(mk(klpi_pkg::CMD_LOOKUP_NAME, 24'h636261, 64'h0000_0000_656D_616E,
                    32'h0, 1'b0));
    push_request(mk(klpi_pkg::CMD_LOOKUP_ID, 24'h636261, 64'h0, 32'h0, 1'b0));
    push_request(mk(klpi_tb_pkg::CMD_UNUSED, 24'hFFFFFF, '1, '1, 1'b1));
    push_request(mk(klpi_pkg::CMD_INSERT, 24'h636261, 64'h0000_0000_656D_616E,
                    32'h0, 1'b1));
    push_request(mk(klpi_pkg::CMD_LOOKUP_NAME, 24'h434241, 64'h5A5A_C300_454D_414E,
                    32'h1234_5678, 1'b1));
    push_request(mk(klpi_pkg::CMD_LOOKUP_ID, 24'h434241, 64'hFFFF_FFFF_FFFF_FFFF,
                    32'h0, 1'b1));
    push_request(mk(klpi_pkg::CMD_INSERT, 24'h434241, 64'h0000_0000_454D_414E,
                    32'h5, 1'b1));
    push_request(mk(klpi_pkg::CMD_INSERT, 24'h0, 64'h0, 32'hFFFF_FFFF, 1'b0));
    push_request(mk(klpi_pkg::CMD_LOOKUP_NAME, 24'h0, 64'h0, 32'h0, 1'b0));
    push_request(mk(klpi_pkg::CMD_LOOKUP_ID, 24'h0, 64'h0, 32'hFFFF_FFFF, 1'b0));
    push_request(mk(klpi_pkg::CMD_INSERT, 24'hFFFFFF, '1, 32'hFFFF_FFFF, 1'b1));
    push_request(mk(klpi_pkg::CMD_LOOKUP_ID, 24'hFFFFFF, 64'h0, 32'hFFFF_FFFF, 1'b0));
    push_request(mk(klpi_pkg::CMD_INSERT, 24'h636261, 64'h0000_0072_6568_746F,
                    32'h0, 1'b1));
    push_request(mk(klpi_pkg::CMD_LOOKUP_ID, 24'h636261, 64'h0, 32'h0, 1'b0));
    push_request(mk(klpi_pkg::CMD_LOOKUP_NAME, 24'hFFFFFF, '1, 32'h0, 1'b1));
    // type with a zero byte in the middle
    push_request(mk(klpi_pkg::CMD_INSERT, 24'h630061, 64'h0000_0000_0000_0078,
                    32'h7, 1'b0));
    push_request(mk(klpi_pkg::CMD_LOOKUP_NAME, 24'h000041, 64'h0000_0000_0000_0058,
                    32'h0, 1'b0));
    push_request(mk(klpi_tb_pkg::CMD_UNUSED, 24'h0, 64'h0, 32'h0, 1'b0));

    // random bursts, most followed by an idle gap
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && left > 0; k++) begin
        push_request(make_req());
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then watch a while for stray results
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results: %0d found, %0d not found, %0d inserted,",
             sb.accepted, sb.seen, sb.per_status[klpi_pkg::ST_FOUND],
             sb.per_status[klpi_pkg::ST_NOT_FOUND], sb.per_status[klpi_pkg::ST_INSERTED]);
    $display("%0d already present, %0d full; %0d of %0d entries stored at the end",
             sb.per_status[klpi_pkg::ST_PRESENT], sb.per_status[klpi_pkg::ST_FULL],
             sb.stored, TBL / 2);
    if (sb.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
